/* sv/tss_pkg.sv */
`timescale 1ns / 1ps

package tss_pkg;

    // Series length limit; a larger term_count is clamped to this.
    localparam int MAX_TERMS = 16;

    // Fixed point format of angles, terms and the sum (signed Q4.28).
    localparam int FRAC_W = 28;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 2 * VAL_W;

    // Field and register widths.
    localparam int IDX_W       = 16;
    localparam int TERM_CFG_W  = 5;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Loop counter widths: j counts terms, k runs from 1 to 2j+1.
    localparam int TERM_W = $clog2(MAX_TERMS + 1);
    localparam int K_W    = $clog2(2 * MAX_TERMS);

    // Shared divider geometry.
    localparam int DIV_W       = 48;
    localparam int DIVISOR_W   = 16;
    localparam int STEP_W      = $clog2(DIV_W + 1);
    localparam int ANGLE_STEPS = DIV_W;
    localparam int MAG_W       = 30;
    localparam int QUOT_STEPS  = MAG_W;

    localparam logic signed [VAL_W-1:0] FIX_PI     = 32'sd842887332;
    localparam logic signed [VAL_W-1:0] FIX_TWO_PI = 32'sd1685774664;
    localparam logic signed [VAL_W-1:0] FIX_ONE    = 32'sd268435456;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TERM_COUNT   = 1'd1;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

/* sv/tss_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend is left aligned
// by the caller so that the quotient ends up in the low bits of the shift
// register after the requested number of steps.
module tss_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tss_pkg::div_req_t                req,
    input  logic [tss_pkg::DIV_W-1:0]        dividend,
    input  logic [tss_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [tss_pkg::DIV_W-1:0]        quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [tss_pkg::STEP_W-1:0]       cnt_reg;
    logic [tss_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [tss_pkg::DIVISOR_W-1:0]    dsr_reg;
    logic [tss_pkg::DIV_W-1:0]        dd_reg;

    logic [tss_pkg::DIVISOR_W:0]      rem_shift;
    logic [tss_pkg::DIVISOR_W:0]      diff;
    logic                             fits;
    logic [tss_pkg::DIVISOR_W-1:0]    rem_next;
    logic [tss_pkg::DIV_W-1:0]        dd_next;

    always_comb
    begin
        rem_shift = {rem_reg, dd_reg[tss_pkg::DIV_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        fits      = !diff[tss_pkg::DIVISOR_W];
        rem_next  = fits ? diff[tss_pkg::DIVISOR_W-1:0] : rem_shift[tss_pkg::DIVISOR_W-1:0];
        dd_next   = {dd_reg[tss_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tss_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dd_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dd_reg  <= dd_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dd_reg;

endmodule

/* sv/tss_mul.sv */
`timescale 1ns / 1ps

// Signed 32 x 32 multiplier with a registered full-width product.
module tss_mul (
    input  logic                                clk,
    input  logic signed [tss_pkg::VAL_W-1:0]    a,
    input  logic signed [tss_pkg::VAL_W-1:0]    b,
    output logic signed [tss_pkg::PROD_W-1:0]   prod
);

    logic signed [tss_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* sv/taylor_sine_sampler_core.sv */
`timescale 1ns / 1ps

// Taylor-series sine sampler. Each request carries a sample index i; the block
// forms the angle x = 2*pi*i/sample_count in signed Q4.28 (pi held as 3.14),
// folds angles above pi to pi - x, sums term_count series terms (at most
// MAX_TERMS) with signed 32-bit saturation and returns one result holding the
// index, the sum and an error flag. An index not below sample_count returns a
// zero value with index_error set. One request is worked on at a time, using
// one shared restoring divider that produces one quotient bit per cycle (a
// 48-bit quotient for the angle, a 30-bit one for every x/k quotient)
// together with one registered 32 x 32 multiplier, both reused for every step
// of every term. in_stall is high while a request is in progress; a finished
// result waits in an output register, so a new request is accepted while it
// is still stalled. The configuration registers must be written only while
// the block is idle.
module taylor_sine_sampler_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [tss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tss_pkg::IDX_W-1:0]            sample_index,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tss_pkg::IDX_W-1:0]            sample_index_echo,
    output logic signed [tss_pkg::VAL_W-1:0]     sine_value,
    output logic                                 index_error
);

    // Sequencer states. The angle is built once per request, then every term
    // walks k = 1 .. 2j+1 through a divide and a multiply.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ADIV,
        S_ADIV_W,
        S_TERM,
        S_QDIV,
        S_QDIV_W,
        S_VMUL,
        S_VMUL_W,
        S_OUT
    } state_t;

    // Configuration registers.
    logic [tss_pkg::IDX_W-1:0]          sample_count_reg;
    logic [tss_pkg::TERM_CFG_W-1:0]     term_count_reg;

    // Sequencer state and working registers.
    state_t                             state_reg, state_next;
    logic [tss_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [tss_pkg::TERM_W-1:0]         terms_reg, terms_next;
    logic [tss_pkg::TERM_W-1:0]         j_reg, j_next;
    logic [tss_pkg::K_W-1:0]            k_reg, k_next;
    logic signed [tss_pkg::VAL_W-1:0]   x_reg, x_next;
    logic signed [tss_pkg::VAL_W-1:0]   v_reg, v_next;
    logic signed [tss_pkg::VAL_W-1:0]   q_reg, q_next;
    logic signed [tss_pkg::VAL_W-1:0]   sum_reg, sum_next;
    logic                               err_reg, err_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    logic [tss_pkg::IDX_W-1:0]          out_idx_reg, out_idx_next;
    logic signed [tss_pkg::VAL_W-1:0]   out_val_reg, out_val_next;
    logic                               out_err_reg, out_err_next;

    // Shared units.
    tss_pkg::div_req_t                  div_req;
    logic [tss_pkg::DIV_W-1:0]          div_dividend;
    logic [tss_pkg::DIVISOR_W-1:0]      div_divisor;
    logic                               div_done;
    logic [tss_pkg::DIV_W-1:0]          div_quot;
    logic signed [tss_pkg::VAL_W-1:0]   mul_a;
    logic signed [tss_pkg::VAL_W-1:0]   mul_b;
    logic signed [tss_pkg::PROD_W-1:0]  mul_prod;

    // Datapath helpers.
    logic signed [tss_pkg::VAL_W-1:0]   angle;
    logic signed [tss_pkg::VAL_W-1:0]   x_abs;
    logic signed [tss_pkg::VAL_W-1:0]   q_mag;
    logic signed [tss_pkg::VAL_W-1:0]   v_prod;
    logic signed [tss_pkg::VAL_W:0]     acc;
    logic [tss_pkg::K_W-1:0]            k_last;

    tss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    tss_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // Configuration writes. An index outside the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= tss_pkg::IDX_W'(1);
            term_count_reg   <= tss_pkg::TERM_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tss_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[tss_pkg::IDX_W-1:0];
                tss_pkg::REG_TERM_COUNT:   term_count_reg   <= cfg_data[tss_pkg::TERM_CFG_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        // The magnitude of the folded angle stays below 2^30, so the divider
        // only needs 30 steps for each x/k quotient.
        x_abs  = x_reg[tss_pkg::VAL_W-1] ? -x_reg : x_reg;
        q_mag  = {{(tss_pkg::VAL_W - tss_pkg::MAG_W){1'b0}}, div_quot[tss_pkg::MAG_W-1:0]};
        angle  = div_quot[tss_pkg::VAL_W-1:0];
        // Taking bits above the fraction is the floor shift of the product;
        // every partial term stays well inside the Q4.28 range.
        v_prod = mul_prod[tss_pkg::FRAC_W + tss_pkg::VAL_W - 1:tss_pkg::FRAC_W];
        acc    = {sum_reg[tss_pkg::VAL_W-1], sum_reg} + {v_prod[tss_pkg::VAL_W-1], v_prod};
        k_last = tss_pkg::K_W'({j_reg, 1'b1});
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        terms_next     = terms_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        v_next         = v_reg;
        q_next         = q_reg;
        sum_next       = sum_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_err_next   = out_err_reg;

        div_req       = '0;
        div_dividend  = '0;
        div_divisor   = '0;
        mul_a         = v_reg;
        mul_b         = q_reg;

        // A waiting result leaves as soon as the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = sample_index;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                // The product 2*pi*i is started here whether or not it is
                // needed; it is only used when the index is in range.
                mul_a    = {{(tss_pkg::VAL_W - tss_pkg::IDX_W){1'b0}}, idx_reg};
                mul_b    = tss_pkg::FIX_TWO_PI;
                sum_next = '0;
                j_next   = '0;
                if (idx_reg >= sample_count_reg)
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    err_next = 1'b0;
                    if (int'(term_count_reg) > tss_pkg::MAX_TERMS)
                    begin
                        terms_next = tss_pkg::TERM_W'(tss_pkg::MAX_TERMS);
                    end
                    else
                    begin
                        terms_next = tss_pkg::TERM_W'(term_count_reg);
                    end
                    state_next = S_ADIV;
                end
            end

            S_ADIV:
            begin
                div_req.start = 1'b1;
                div_req.steps = tss_pkg::STEP_W'(tss_pkg::ANGLE_STEPS);
                div_dividend  = mul_prod[tss_pkg::DIV_W-1:0];
                div_divisor   = sample_count_reg;
                state_next    = S_ADIV_W;
            end

            S_ADIV_W:
            begin
                if (div_done)
                begin
                    x_next     = (angle > tss_pkg::FIX_PI) ? tss_pkg::FIX_PI - angle : angle;
                    state_next = S_TERM;
                end
            end

            S_TERM:
            begin
                if (j_reg < terms_reg)
                begin
                    v_next     = j_reg[0] ? -tss_pkg::FIX_ONE : tss_pkg::FIX_ONE;
                    k_next     = tss_pkg::K_W'(1);
                    state_next = S_QDIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_QDIV:
            begin
                div_req.start = 1'b1;
                div_req.steps = tss_pkg::STEP_W'(tss_pkg::QUOT_STEPS);
                div_dividend  = {x_abs[tss_pkg::MAG_W-1:0],
                                 {(tss_pkg::DIV_W - tss_pkg::MAG_W){1'b0}}};
                div_divisor   = tss_pkg::DIVISOR_W'(k_reg);
                state_next    = S_QDIV_W;
            end

            S_QDIV_W:
            begin
                if (div_done)
                begin
                    // Dividing magnitudes and restoring the sign truncates
                    // toward zero.
                    q_next     = x_reg[tss_pkg::VAL_W-1] ? -q_mag : q_mag;
                    state_next = S_VMUL;
                end
            end

            S_VMUL:
            begin
                state_next = S_VMUL_W;
            end

            S_VMUL_W:
            begin
                v_next = v_prod;
                if (k_reg == k_last)
                begin
                    if (acc[tss_pkg::VAL_W] != acc[tss_pkg::VAL_W-1])
                    begin
                        sum_next = acc[tss_pkg::VAL_W] ?
                                   {1'b1, {(tss_pkg::VAL_W - 1){1'b0}}} :
                                   {1'b0, {(tss_pkg::VAL_W - 1){1'b1}}};
                    end
                    else
                    begin
                        sum_next = acc[tss_pkg::VAL_W-1:0];
                    end
                    j_next     = j_reg + 1'b1;
                    state_next = S_TERM;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_QDIV;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_val_next   = sum_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            terms_reg     <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            x_reg         <= '0;
            v_reg         <= '0;
            q_reg         <= '0;
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_val_reg   <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            terms_reg     <= terms_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            x_reg         <= x_next;
            v_reg         <= v_next;
            q_reg         <= q_next;
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_val_reg   <= out_val_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign sample_index_echo = out_idx_reg;
    assign sine_value        = out_val_reg;
    assign index_error       = out_err_reg;

endmodule

/* sv/tss_checker.sv */
`timescale 1ns / 1ps

// Port-level checks for the sine sampler.
module tss_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [tss_pkg::IDX_W-1:0]            sample_index_echo,
    input  logic signed [tss_pkg::VAL_W-1:0]     sine_value,
    input  logic                                 index_error
);

    // Only one request is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another was in progress");

    // A result appears only at the end of a request that held the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without a request in progress");

    // An out-of-range index always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> sine_value == '0)
        else $error("index error with nonzero value");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sine_value)
                                   && $stable(sample_index_echo) && $stable(index_error))
        else $error("stalled result changed");

endmodule

bind taylor_sine_sampler_core tss_checker u_tss_checker (.*);

/* test/tb_taylor_sine_sampler_core.sv */
`timescale 1ns / 1ps

module tb_taylor_sine_sampler_core;

    import tss_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 8;
    // Cycles the receiver refuses results during the back-pressure phase. With one
    // term a request is short next to this hold, so the output register and the core
    // both fill up long before the hold ends and the input has to stall.
    localparam int     HOLD_CYCLES  = 1500;
    // Quiet cycles after the last result, before a register write or the end.
    localparam int     SETTLE       = 8;
    localparam int     TAIL_CYCLES  = 200;
    // The slowest request is one with sixteen terms. The run has about 100
    // requests, so this bound is several times the worst case even if every one
    // of them took the longest path and every stall at both ends.
    localparam longint LIMIT_CYCLES = 5_000_000;

    localparam longint Q_MAX = 2147483647;
    localparam longint Q_MIN = -Q_MAX - 1;

    // One result as the core should return it.
    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] value;
        logic                    err;
    } sine_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                          cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;

    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [IDX_W-1:0]              sample_index = '0;

    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [IDX_W-1:0]              sample_index_echo;
    logic signed [VAL_W-1:0]       sine_value;
    logic                          index_error;

    // Indexes waiting to be sent, and the results owed by the core in order.
    logic [IDX_W-1:0] pending_q[$];
    sine_result_t     sine_q[$];

    // Our copy of the two configuration registers, at their reset values.
    logic [IDX_W-1:0]      shadow_sample_count = 16'd1;
    logic [TERM_CFG_W-1:0] shadow_term_count   = 5'd1;

    int           error_count = 0;
    bit           in_taken    = 1'b0;
    bit           idle_on     = 1'b1;
    int           send_gap    = 0;
    int           stall_gap   = 0;
    int           hold_left   = 0;
    int           hold_ask    = 0;
    int           hold_done   = 0;
    sine_result_t want;

    taylor_sine_sampler_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample_index      (sample_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sample_index_echo (sample_index_echo),
        .sine_value        (sine_value),
        .index_error       (index_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Clamp a sum to the signed 32-bit range of Q4.28.
    function automatic longint clamp_q428(input longint s);
        if (s > Q_MAX)
            return Q_MAX;
        if (s < Q_MIN)
            return Q_MIN;
        return s;
    endfunction

    // Work out the sine the core should return for one index. The angle is
    // 2*pi*i/N with a truncating divide, folded to pi - x above pi. Each term
    // starts at plus or minus one and is multiplied 2j+1 times by x/k, where
    // the quotient truncates toward zero and the product is floored back to
    // Q4.28. Each term is added to the sum with saturation.
    function automatic sine_result_t predict_sine(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] n,
                                                  input logic [TERM_CFG_W-1:0] tc);
        sine_result_t r;
        longint       angle;
        longint       term;
        longint       quot;
        longint       acc;
        int           terms;
        int           j;
        int           k;

        r.idx   = idx;
        r.value = '0;
        r.err   = 1'b0;
        // An index at or past N is an error; with N of zero every index is.
        if (idx >= n)
        begin
            r.err = 1'b1;
            return r;
        end
        terms = (int'(tc) > MAX_TERMS) ? MAX_TERMS : int'(tc);
        angle = (2 * longint'(FIX_PI) * longint'(idx)) / longint'(n);
        if (angle > longint'(FIX_PI))
            angle = longint'(FIX_PI) - angle;
        acc = 0;
        for (j = 0; j < terms; j++)
        begin
            term = (j % 2 == 1) ? -longint'(FIX_ONE) : longint'(FIX_ONE);
            for (k = 1; k <= 2 * j + 1; k++)
            begin
                quot = angle / longint'(k);
                term = (term * quot) >>> FRAC_W;
            end
            acc = clamp_q428(acc + clamp_q428(term));
        end
        r.value = acc[VAL_W-1:0];
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Mostly indexes inside the period, some past its end, some anywhere.
    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] n);
        int r;

        r = $urandom_range(0, 9);
        if (n == 0 || r == 9)
            return IDX_W'($urandom_range(0, 65535));
        if (r == 8 && n != 16'hFFFF)
            return IDX_W'($urandom_range(n, 65535));
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    // Monitor. Everything is sampled at the rising edge, where the handshakes
    // complete. A register write updates our copy of the configuration, a
    // delivered result is checked against the oldest expectation, and an
    // accepted request gets its expected result queued. The check runs before
    // the push so a stray result can never be matched to the request that was
    // taken on the same edge.
    always @(posedge clk)
    begin
        in_taken = in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SAMPLE_COUNT)
                    shadow_sample_count = cfg_data[IDX_W-1:0];
                else if (cfg_index == REG_TERM_COUNT)
                    shadow_term_count = cfg_data[TERM_CFG_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                if (sine_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with nothing expected: index %0d value %0d err %0b",
                             $time, sample_index_echo, sine_value, index_error);
                end
                else
                begin
                    want = sine_q.pop_front();
                    if (sample_index_echo !== want.idx)
                    begin
                        error_count++;
                        $display("%0t: sample_index_echo expected %0d actual %0d",
                                 $time, want.idx, sample_index_echo);
                    end
                    if (sine_value !== want.value)
                    begin
                        error_count++;
                        $display("%0t: sine_value (index %0d) expected %0d actual %0d",
                                 $time, want.idx, want.value, sine_value);
                    end
                    if (index_error !== want.err)
                    begin
                        error_count++;
                        $display("%0t: index_error (index %0d) expected %0b actual %0b",
                                 $time, want.idx, want.err, index_error);
                    end
                end
            end

            if (in_valid && !in_stall)
                sine_q.push_back(predict_sine(sample_index, shadow_sample_count,
                                              shadow_term_count));
        end
    end

    // Driver. On each falling edge it retires the request taken at the last
    // rising edge, then either idles for a gap or offers the head of the
    // pending queue. A request that was not taken is simply offered again with
    // the same index, so valid and payload hold steady while stalled. Only one
    // assignment to in_valid happens per edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_taken)
            begin
                void'(pending_q.pop_front());
                send_gap = idle_on ? pick_gap() : 0;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                in_valid     <= 1'b1;
                sample_index <= pending_q[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. It stalls in random gaps, and on request holds off for a long
    // stretch that it counts here, so the core backs up to its input.
    always @(negedge clk)
    begin
        if (hold_ask != hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_ask;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_gap > 0)
        begin
            stall_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_gap = idle_on ? pick_gap() : 0;
        end
    end

    // Wait until every request has gone out and every result has come back.
    // This is checked on the falling edge, where the queues are quiet.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(pending_q.size() == 0 && !in_valid && sine_q.size() == 0));
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Reprogram both registers once the core is idle. The term count goes out
    // with random upper bits, which the core has to ignore.
    task automatic configure(input logic [IDX_W-1:0] n, input logic [TERM_CFG_W-1:0] tc);
        wait_drained();
        write_reg(REG_SAMPLE_COUNT, n);
        write_reg(REG_TERM_COUNT,
                  {CFG_DATA_W'($urandom_range(0, 2047)) << TERM_CFG_W} | CFG_DATA_W'(tc));
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input logic [IDX_W-1:0] n,
                                input logic [TERM_CFG_W-1:0] tc, input bit with_idle,
                                input bit long_hold);
        int i;

        configure(n, tc);
        idle_on = with_idle;
        if (long_hold)
            hold_ask++;
        for (i = 0; i < count; i++)
            pending_q.push_back(pick_index(n));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, one point per period and one term: index zero gives
        // exactly zero, anything else is out of range.
        pending_q.push_back(16'd0);
        pending_q.push_back(16'd1);
        pending_q.push_back(16'hFFFF);

        // Widest period and the full series, around zero, pi/2, pi and the top.
        configure(16'hFFFF, 5'd16);
        pending_q.push_back(16'd0);
        pending_q.push_back(16'd16384);
        pending_q.push_back(16'd32767);
        pending_q.push_back(16'd32768);
        pending_q.push_back(16'd65534);

        // A term count above the limit is clamped. Index 2 lands exactly on pi
        // and is not folded; index 3 is folded to a negative angle.
        configure(16'd4, 5'd31);
        pending_q.push_back(16'd0);
        pending_q.push_back(16'd1);
        pending_q.push_back(16'd2);
        pending_q.push_back(16'd3);
        pending_q.push_back(16'd4);

        // No terms: the sum is zero without an error, unless out of range.
        configure(16'd8, 5'd0);
        pending_q.push_back(16'd3);
        pending_q.push_back(16'd8);

        // A period of zero points flags every index.
        configure(16'd0, 5'd5);
        pending_q.push_back(16'd0);
        pending_q.push_back(16'hFFFF);
        pending_q.push_back(16'h5A5A);

        // Two points: index 1 is exactly pi.
        configure(16'd2, 5'd2);
        pending_q.push_back(16'd0);
        pending_q.push_back(16'd1);
        pending_q.push_back(16'd2);

        // Random phases. Most use short series so that the run stays quick;
        // one small phase takes the full or clamped series. The first one also
        // holds the receiver off for a long time, and one runs with no gaps.
        random_phase(16, 16'($urandom_range(2, 64)), 5'd1, 1'b1, 1'b1);
        random_phase(14, 16'($urandom_range(0, 65535)), 5'($urandom_range(0, 6)), 1'b0, 1'b0);
        random_phase(14, 16'hFFFF, 5'($urandom_range(1, 8)), 1'b1, 1'b0);
        random_phase(14, 16'($urandom_range(1, 16)), 5'($urandom_range(1, 5)), 1'b1, 1'b0);
        random_phase(5, 16'($urandom_range(0, 65535)), 5'($urandom_range(16, 31)), 1'b1, 1'b0);
        random_phase(8, 16'd1, 5'($urandom_range(0, 6)), 1'b1, 1'b0);
        random_phase(10, 16'($urandom_range(1, 1000)), 5'($urandom_range(2, 4)), 1'b1, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* taylor_sine_sampler_core.f */
sv/tss_pkg.sv
sv/tss_div.sv
sv/tss_mul.sv
sv/taylor_sine_sampler_core.sv
sv/tss_checker.sv
test/tb_taylor_sine_sampler_core.sv
